// ===== rtl/core/urbe_pkg.sv =====
// Package for the UART ring buffer engine: shared types, codes and defaults.
// Used by the interfaces, the controller, the datapath and the top level.
// Depends on nothing.
package urbe_pkg;

  // Default ring sizes; each ring keeps one slot empty.
  localparam int URBE_RX_DEPTH = 16;
  localparam int URBE_TX_DEPTH = 16;
  localparam int URBE_BYTE_W   = 8;

  // Bit positions of the latched receive error flags.
  localparam int ERR_FRAME_BIT    = 0;
  localparam int ERR_OVERRUN_BIT  = 1;
  localparam int ERR_OVERFLOW_BIT = 2;
  localparam int ERR_W            = 3;

  // Event kinds carried by an input beat.
  typedef enum logic [1:0] {
    CMD_RX_BYTE  = 2'd0,
    CMD_HOST_RD  = 2'd1,
    CMD_HOST_WR  = 2'd2,
    CMD_TX_READY = 2'd3
  } urbe_cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_LOAD = 2'd2
  } urbe_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
    logic load;
  } urbe_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } urbe_sts_t;

  // One result beat.
  typedef struct packed {
    logic [URBE_BYTE_W-1:0] read_byte;
    logic                   err_frame;
    logic                   err_overrun;
    logic                   err_overflow;
    logic                   no_data;
    logic                   write_accepted;
    logic                   tx_valid;
    logic [URBE_BYTE_W-1:0] tx_byte;
    logic                   tx_irq_enable;
  } urbe_result_t;

endpackage

// ===== rtl/core/urbe_if.sv =====
// Valid/ready channel interfaces for the input events and the result beats.
// Depends on urbe_pkg for the command type and the byte width.
interface urbe_in_if import urbe_pkg::*; ();
  logic                   valid;
  logic                   ready;
  urbe_cmd_t              cmd;
  logic [URBE_BYTE_W-1:0] data_byte;
  logic                   frame_error_in;
  logic                   overrun_error_in;

  modport source (output valid, cmd, data_byte, frame_error_in, overrun_error_in,
                  input ready);
  modport sink   (input valid, cmd, data_byte, frame_error_in, overrun_error_in,
                  output ready);
endinterface

interface urbe_out_if import urbe_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [URBE_BYTE_W-1:0] read_byte;
  logic                   err_frame;
  logic                   err_overrun;
  logic                   err_overflow;
  logic                   no_data;
  logic                   write_accepted;
  logic                   tx_valid;
  logic [URBE_BYTE_W-1:0] tx_byte;
  logic                   tx_irq_enable;

  modport source (output valid, read_byte, err_frame, err_overrun, err_overflow,
                  no_data, write_accepted, tx_valid, tx_byte, tx_irq_enable,
                  input ready);
  modport sink   (input valid, read_byte, err_frame, err_overrun, err_overflow,
                  no_data, write_accepted, tx_valid, tx_byte, tx_irq_enable,
                  output ready);
endinterface

// ===== rtl/core/urbe_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
module urbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/urbe_ctrl.sv =====
// Controller state machine of the UART ring buffer engine.
// Depends on urbe_pkg for the state enum and the command/status structs.
module urbe_ctrl import urbe_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  urbe_sts_t sts,
  output urbe_ctl_t ctl
);

  urbe_state_t state_r;
  urbe_state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: take a beat, execute it, then hand the result over.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs decoded from the current state.
  always_comb begin
    in_ready    = 1'b0;
    ctl.capture = 1'b0;
    ctl.execute = 1'b0;
    ctl.load    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      ST_EXEC: begin
        ctl.execute = 1'b1;
      end
      ST_LOAD: begin
        ctl.load = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/urbe_dp.sv =====
// Datapath of the UART ring buffer engine: ring pointers, error flags, the
// two byte stores and the output register. Depends on urbe_pkg and urbe_ram.
module urbe_dp import urbe_pkg::*; #(
  parameter int RX_DEPTH = URBE_RX_DEPTH,
  parameter int TX_DEPTH = URBE_TX_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  urbe_ctl_t              ctl,
  output urbe_sts_t              sts,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  urbe_cmd_t              in_cmd,
  input  logic [URBE_BYTE_W-1:0] in_data_byte,
  input  logic                   in_frame_error_in,
  input  logic                   in_overrun_error_in,
  input  logic                   out_ready,
  output logic                   out_valid,
  output urbe_result_t           out_res
);

  localparam int RX_AW = $clog2(RX_DEPTH);
  localparam int TX_AW = $clog2(TX_DEPTH);
  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  // Captured input beat.
  urbe_cmd_t              item_cmd_r;
  logic [URBE_BYTE_W-1:0] item_data_r;
  logic                   item_fe_r;
  logic                   item_ov_r;

  // Ring and flag state.
  logic [RX_AW-1:0] rx_wp_r, rx_wp_nxt, rx_rp_r, rx_rp_nxt;
  logic [TX_AW-1:0] tx_wp_r, tx_wp_nxt, tx_rp_r, tx_rp_nxt;
  logic [ERR_W-1:0] last_err_r, last_err_nxt;
  logic             irq_r, irq_nxt;
  logic             enable_r;

  // Result waiting for the popped byte.
  urbe_result_t pend_r, pend_nxt;
  logic         pend_rx_pop_r, pend_rx_pop_nxt;
  logic         pend_tx_pop_r, pend_tx_pop_nxt;

  // Output register.
  urbe_result_t out_r, out_nxt;
  logic         out_valid_r, out_valid_nxt;

  // Store ports.
  logic                   rx_we, rx_re, tx_we, tx_re;
  logic [URBE_BYTE_W-1:0] rx_rdata, tx_rdata;

  // Advanced pointers with wrap-around at the ring size.
  logic [RX_AW-1:0] rx_wp_inc, rx_rp_inc;
  logic [TX_AW-1:0] tx_wp_inc, tx_rp_inc;
  logic             rx_full, rx_empty, tx_full, tx_empty;

  assign rx_wp_inc = (rx_wp_r == RX_LAST) ? '0 : rx_wp_r + RX_AW'(1);
  assign rx_rp_inc = (rx_rp_r == RX_LAST) ? '0 : rx_rp_r + RX_AW'(1);
  assign tx_wp_inc = (tx_wp_r == TX_LAST) ? '0 : tx_wp_r + TX_AW'(1);
  assign tx_rp_inc = (tx_rp_r == TX_LAST) ? '0 : tx_rp_r + TX_AW'(1);

  assign rx_full  = (rx_wp_inc == rx_rp_r);
  assign rx_empty = (rx_wp_r == rx_rp_r);
  assign tx_full  = (tx_wp_inc == tx_rp_r);
  assign tx_empty = (tx_wp_r == tx_rp_r);

  // Event execution: pointer, flag and store updates plus the pending result.
  always_comb begin
    rx_wp_nxt       = rx_wp_r;
    rx_rp_nxt       = rx_rp_r;
    tx_wp_nxt       = tx_wp_r;
    tx_rp_nxt       = tx_rp_r;
    last_err_nxt    = last_err_r;
    irq_nxt         = irq_r;
    pend_nxt        = '0;
    pend_rx_pop_nxt = 1'b0;
    pend_tx_pop_nxt = 1'b0;
    rx_we           = 1'b0;
    rx_re           = 1'b0;
    tx_we           = 1'b0;
    tx_re           = 1'b0;
    if (ctl.execute) begin
      case (item_cmd_r)
        CMD_RX_BYTE: begin
          if (enable_r) begin
            last_err_nxt                   = '0;
            last_err_nxt[ERR_FRAME_BIT]    = item_fe_r;
            last_err_nxt[ERR_OVERRUN_BIT]  = item_ov_r;
            last_err_nxt[ERR_OVERFLOW_BIT] = rx_full;
            if (!rx_full) begin
              rx_we     = 1'b1;
              rx_wp_nxt = rx_wp_inc;
            end
          end
        end
        CMD_HOST_RD: begin
          if (rx_empty) begin
            pend_nxt.no_data = 1'b1;
          end else begin
            rx_re                 = 1'b1;
            rx_rp_nxt             = rx_rp_inc;
            pend_rx_pop_nxt       = 1'b1;
            pend_nxt.err_frame    = last_err_r[ERR_FRAME_BIT];
            pend_nxt.err_overrun  = last_err_r[ERR_OVERRUN_BIT];
            pend_nxt.err_overflow = last_err_r[ERR_OVERFLOW_BIT];
          end
        end
        CMD_HOST_WR: begin
          if (!tx_full) begin
            tx_we                   = 1'b1;
            tx_wp_nxt               = tx_wp_inc;
            irq_nxt                 = 1'b1;
            pend_nxt.write_accepted = 1'b1;
          end
        end
        CMD_TX_READY: begin
          if (enable_r) begin
            if (!tx_empty) begin
              tx_re             = 1'b1;
              tx_rp_nxt         = tx_rp_inc;
              pend_tx_pop_nxt   = 1'b1;
              pend_nxt.tx_valid = 1'b1;
            end else begin
              irq_nxt = 1'b0;
            end
          end
        end
        default: begin
          irq_nxt = irq_r;
        end
      endcase
    end
    pend_nxt.tx_irq_enable = irq_nxt;
  end

  // Output beat: the pending result with the popped bytes filled in.
  always_comb begin
    out_nxt           = pend_r;
    out_nxt.read_byte = pend_rx_pop_r ? rx_rdata : '0;
    out_nxt.tx_byte   = pend_tx_pop_r ? tx_rdata : '0;
  end

  // The output slot frees when its beat is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_wp_r     <= '0;
      rx_rp_r     <= '0;
      tx_wp_r     <= '0;
      tx_rp_r     <= '0;
      last_err_r  <= '0;
      irq_r       <= 1'b0;
      enable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rx_wp_r     <= rx_wp_nxt;
      rx_rp_r     <= rx_rp_nxt;
      tx_wp_r     <= tx_wp_nxt;
      tx_rp_r     <= tx_rp_nxt;
      last_err_r  <= last_err_nxt;
      irq_r       <= irq_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: captured beat, pending result and output beat.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_cmd_r  <= in_cmd;
      item_data_r <= in_data_byte;
      item_fe_r   <= in_frame_error_in;
      item_ov_r   <= in_overrun_error_in;
    end
    if (ctl.execute) begin
      pend_r        <= pend_nxt;
      pend_rx_pop_r <= pend_rx_pop_nxt;
      pend_tx_pop_r <= pend_tx_pop_nxt;
    end
    if (ctl.load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  // Receive ring store.
  urbe_ram #(
    .WIDTH (URBE_BYTE_W),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wp_inc),
    .wdata (item_data_r),
    .re    (rx_re),
    .raddr (rx_rp_inc),
    .rdata (rx_rdata)
  );

  // Transmit ring store.
  urbe_ram #(
    .WIDTH (URBE_BYTE_W),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wp_inc),
    .wdata (item_data_r),
    .re    (tx_re),
    .raddr (tx_rp_inc),
    .rdata (tx_rdata)
  );

endmodule

// ===== rtl/core/uart_ring_buffer_engine_top.sv =====
// UART ring buffer engine: one event in, one result beat out.
// Flow: an event beat is captured, then executed with the store access, then its
// result is loaded into the output register; the next event is taken only after
// that load, and the load waits while the output beat is stalled.
// Reset: synchronous, active low; clears pointers, flags, enable and valids.
// Depends on urbe_pkg, urbe_if, urbe_ctrl, urbe_dp and urbe_ram.
module uart_ring_buffer_engine_top import urbe_pkg::*; #(
  parameter int RX_DEPTH = URBE_RX_DEPTH,
  parameter int TX_DEPTH = URBE_TX_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  urbe_in_if.sink     in_ch,
  urbe_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  urbe_ctl_t    ctl;
  urbe_sts_t    sts;
  logic         in_ready;
  logic         out_valid;
  urbe_result_t out_res;

  // Controller.
  urbe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // Datapath.
  urbe_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_cmd              (in_ch.cmd),
    .in_data_byte        (in_ch.data_byte),
    .in_frame_error_in   (in_ch.frame_error_in),
    .in_overrun_error_in (in_ch.overrun_error_in),
    .out_ready           (out_ch.ready),
    .out_valid           (out_valid),
    .out_res             (out_res)
  );

  // Channel wiring.
  assign in_ch.ready           = in_ready;
  assign out_ch.valid          = out_valid;
  assign out_ch.read_byte      = out_res.read_byte;
  assign out_ch.err_frame      = out_res.err_frame;
  assign out_ch.err_overrun    = out_res.err_overrun;
  assign out_ch.err_overflow   = out_res.err_overflow;
  assign out_ch.no_data        = out_res.no_data;
  assign out_ch.write_accepted = out_res.write_accepted;
  assign out_ch.tx_valid       = out_res.tx_valid;
  assign out_ch.tx_byte        = out_res.tx_byte;
  assign out_ch.tx_irq_enable  = out_res.tx_irq_enable;

endmodule

// ===== rtl/core/urbe_chk.sv =====
// Port-level checker for the UART ring buffer engine, bound to the top level.
// Depends on urbe_pkg for the byte width.
module urbe_chk import urbe_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [URBE_BYTE_W-1:0] read_byte,
  input logic                   err_frame,
  input logic                   err_overrun,
  input logic                   err_overflow,
  input logic                   no_data,
  input logic                   write_accepted,
  input logic                   tx_valid,
  input logic [URBE_BYTE_W-1:0] tx_byte
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its bytes.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(read_byte) && $stable(tx_byte))
    else $error("result payload changed while stalled");

  // At most one event outcome is reported per beat.
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $countones({no_data, write_accepted, tx_valid}) <= 1)
    else $error("more than one outcome flag set");

  // An empty read carries no byte and no error flags.
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && no_data |->
      read_byte == '0 && !err_frame && !err_overrun && !err_overflow)
    else $error("empty read carries data");

  // No transmit byte without a transmit pop.
  a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !tx_valid |-> tx_byte == '0)
    else $error("transmit byte without transmit pop");

endmodule

bind uart_ring_buffer_engine_top urbe_chk u_urbe_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .read_byte      (out_ch.read_byte),
  .err_frame      (out_ch.err_frame),
  .err_overrun    (out_ch.err_overrun),
  .err_overflow   (out_ch.err_overflow),
  .no_data        (out_ch.no_data),
  .write_accepted (out_ch.write_accepted),
  .tx_valid       (out_ch.tx_valid),
  .tx_byte        (out_ch.tx_byte)
);
